### sv/mfqs_pkg.sv
// mfqs_pkg: shared types, widths and codes of the multilevel feedback queue scheduler
// depends on nothing; imported by mfqs_age, the top level and the bench
package mfqs_pkg;

	// payload field widths
	localparam int ID_W      = 6;
	localparam int LVL_W     = 3;
	localparam int NOW_W     = 32;
	localparam int CNT_W     = 9;
	localparam int THR_W     = 32;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 4;

	// stream packing
	localparam int S_DATA_W  = 48;
	localparam int S_ID_LO   = 0;
	localparam int S_LVL_LO  = S_ID_LO + ID_W;
	localparam int S_NOW_LO  = S_LVL_LO + LVL_W;
	localparam int M_DATA_W  = 24;
	localparam int M_PAD_W   = M_DATA_W - ID_W - LVL_W - 1 - CNT_W;

	// defaults
	localparam int DEF_NUM_TASKS  = 64;
	localparam int DEF_NUM_LEVELS = 5;
	localparam int DEF_TIME_WIDTH = 32;
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(200);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_AGE_THR = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_ID = CFG_IDX_W'(1);

	typedef enum logic [MODE_W-1:0] {
		MODE_ENQ = 2'd0,
		MODE_SEL = 2'd1,
		MODE_REM = 2'd2,
		MODE_AGE = 2'd3
	} mode_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DEC,
		S_SEL_RD,
		S_SEL_DAT,
		S_RM_LV,
		S_RM_CHK,
		S_RM_RD,
		S_RM_CMP,
		S_RM_END,
		S_PUT,
		S_BS_LV,
		S_BS_RD,
		S_BS_ID,
		S_BS_TM,
		S_BS_PRD,
		S_BS_PID,
		S_DONE
	} state_t;

endpackage

### sv/mfqs_ram.sv
// mfqs_ram: single write port, single read port memory with registered read data
// depends on nothing
module mfqs_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### sv/mfqs_age.sv
// mfqs_age: shared wait-time unit, wrapping subtract and compare against the threshold
// depends on mfqs_pkg
module mfqs_age #(
	parameter int TW = 32
) (
	input  logic [TW-1:0]              now_v,
	input  logic [TW-1:0]              entry,
	input  logic [mfqs_pkg::THR_W-1:0] thr,
	output logic                       older
);
	import mfqs_pkg::*;

	localparam int CW = (TW > THR_W) ? TW : THR_W;

	logic [TW-1:0] wait_v;

	// waiting time wraps at the time width
	assign wait_v = now_v - entry;
	assign older  = CW'(wait_v) > CW'(thr);

endmodule

### sv/multilevel_feedback_queue_scheduler_top.sv
// multilevel_feedback_queue_scheduler_top: queue pointers, sequencer and memories
// depends on mfqs_pkg, mfqs_ram, mfqs_age
//
// channel  dir  handshake          payload
// s        in   s_tvalid/s_tready  s_tdata: task_id, level, now; s_tuser: mode
// m        out  m_tvalid/m_tready  m_tdata: chosen_id, chosen_level, op_ok, boosted_count
// cfg      in   cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// from accept to result: enqueue passes decode and put, select passes decode and two read
// steps (decode only when every level is empty), remove scans every entry of the task's
// level (no scan for the idle id). age boost scans each level but level 0 entry by entry,
// then runs a remove and an enqueue for each picked task over the single queue memory port.
// reset clears pointers, fill counts and task table valid bits at once.
// a finished result waits in the output register while the next request is taken.
module multilevel_feedback_queue_scheduler_top #(
	parameter int NUM_TASKS  = mfqs_pkg::DEF_NUM_TASKS,
	parameter int NUM_LEVELS = mfqs_pkg::DEF_NUM_LEVELS,
	parameter int TIME_WIDTH = mfqs_pkg::DEF_TIME_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [mfqs_pkg::S_DATA_W-1:0]  s_tdata,   // task_id, level, now, zero pad
	input  logic [mfqs_pkg::MODE_W-1:0]    s_tuser,   // mode
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [mfqs_pkg::M_DATA_W-1:0]  m_tdata,   // chosen_id, chosen_level, op_ok,
	                                                  // boosted_count, zero pad
	output logic                           m_tuser,   // chose_idle
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [mfqs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mfqs_pkg::THR_W-1:0]     cfg_data
);
	import mfqs_pkg::*;

	localparam int TW     = TIME_WIDTH;
	localparam int QI_W   = $clog2(NUM_TASKS);
	localparam int TI_W   = $clog2(NUM_TASKS);
	localparam int FILL_W = $clog2(NUM_TASKS + 1);
	localparam int PS_W   = FILL_W + 1;
	localparam int LV_W   = $clog2(NUM_LEVELS);
	localparam int SA_W   = $clog2(NUM_LEVELS * NUM_TASKS);
	localparam int TT_W   = LV_W + TW;

	state_t state_q, state_d;

	// configuration
	logic [THR_W-1:0] thr_q;
	logic [ID_W-1:0]  idle_q;

	// latched request
	mode_t            mode_q;
	logic [ID_W-1:0]  id_q;
	logic [LVL_W-1:0] lvl_q;
	logic [TW-1:0]    now_q;

	// queue pointers
	logic [QI_W-1:0]   head_q [NUM_LEVELS];
	logic [QI_W-1:0]   tail_q [NUM_LEVELS];
	logic [FILL_W-1:0] fill_q [NUM_LEVELS];
	logic [NUM_TASKS-1:0] tv_q;
	logic              tv_rd_q;

	// working registers
	logic [ID_W-1:0]   op_id_q;
	logic [ID_W-1:0]   pid_q;
	logic [LV_W-1:0]   op_lv_q;
	logic [LV_W-1:0]   bl_q;
	logic [FILL_W-1:0] k_q, cnt_q, p_q;
	logic [QI_W-1:0]   rpos_q, prev_q;
	logic              found_q, boost_q;
	logic [CNT_W-1:0]  moved_q;

	// result
	logic [ID_W-1:0]  res_id_q;
	logic [LVL_W-1:0] res_lv_q;
	logic             res_idle_q, res_ok_q;
	logic             m_tvalid_q;
	logic [ID_W-1:0]  m_id_q;
	logic [LVL_W-1:0] m_lv_q;
	logic             m_idle_q, m_ok_q;
	logic [CNT_W-1:0] m_cnt_q;

	// memory ports
	logic            st_we;
	logic [SA_W-1:0] st_waddr, st_raddr;
	logic [ID_W-1:0] st_wdata, st_rdata;
	logic            tt_we;
	logic [TI_W-1:0] tt_waddr, tt_raddr;
	logic [TT_W-1:0] tt_wdata, tt_rdata;
	logic            pk_we;
	logic [TI_W-1:0] pk_waddr, pk_raddr;
	logic [ID_W-1:0] pk_rdata;
	logic [ID_W-1:0] pk_rdata_w;

	// datapath helpers
	logic [LV_W-1:0]   cur_lv, sel_lv, clamp_lv;
	logic              sel_any;
	logic [FILL_W-1:0] cur_fill;
	logic [QI_W-1:0]   cur_head, cur_tail, pos;
	logic [PS_W-1:0]   pos_sum;
	logic [SA_W-1:0]   base;
	logic [LV_W-1:0]   tt_lv;
	logic [TW-1:0]     tt_time;
	logic              older, put_ok, rm_skip;

	// memories
	mfqs_ram #(.DEPTH(NUM_LEVELS * NUM_TASKS), .WIDTH(ID_W)) u_store (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	mfqs_ram #(.DEPTH(NUM_TASKS), .WIDTH(TT_W)) u_task_tab (
		.clk(clk), .we(tt_we), .waddr(tt_waddr), .wdata(tt_wdata),
		.raddr(tt_raddr), .rdata(tt_rdata)
	);

	mfqs_ram #(.DEPTH(NUM_TASKS), .WIDTH(ID_W)) u_picked (
		.clk(clk), .we(pk_we), .waddr(pk_waddr), .wdata(pk_rdata_w),
		.raddr(pk_raddr), .rdata(pk_rdata)
	);

	assign pk_rdata_w = pid_q;

	// shared wait-time compare
	mfqs_age #(.TW(TW)) u_age (
		.now_v(now_q), .entry(tt_time), .thr(thr_q), .older(older)
	);

	// task table entries never written read as zero
	assign tt_lv   = tv_rd_q ? tt_rdata[TT_W-1:TW] : '0;
	assign tt_time = tv_rd_q ? tt_rdata[TW-1:0] : '0;

	// level under work and its pointers
	assign cur_lv   = (state_q == S_BS_LV || state_q == S_BS_RD) ? bl_q : op_lv_q;
	assign cur_fill = fill_q[cur_lv];
	assign cur_head = head_q[cur_lv];
	assign cur_tail = tail_q[cur_lv];
	assign pos_sum  = PS_W'(cur_head) + PS_W'(k_q);
	assign pos      = (32'(pos_sum) >= NUM_TASKS) ? QI_W'(32'(pos_sum) - NUM_TASKS)
	                                              : QI_W'(pos_sum);
	assign base     = SA_W'(32'(cur_lv) * NUM_TASKS);
	assign put_ok   = (32'(op_id_q) < NUM_TASKS) && (32'(cur_fill) < NUM_TASKS);
	assign rm_skip  = (op_id_q == idle_q) || !(32'(op_id_q) < NUM_TASKS);

	// enqueue level clamp
	assign clamp_lv = (32'(lvl_q) >= NUM_LEVELS) ? LV_W'(NUM_LEVELS - 1) : LV_W'(lvl_q);

	// lowest-numbered (highest priority) non-empty level
	always_comb begin
		sel_lv  = '0;
		sel_any = 1'b0;
		for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
			if (fill_q[l] != '0) begin
				sel_lv  = LV_W'(l);
				sel_any = 1'b1;
			end
		end
	end

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tuser   = m_idle_q;
	assign m_tdata   = {{M_PAD_W{1'b0}}, m_cnt_q, m_ok_q, m_lv_q, m_id_q};

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer next state and memory controls
	always_comb begin
		state_d  = state_q;
		st_we    = 1'b0;
		st_waddr = base + SA_W'(prev_q);
		st_wdata = st_rdata;
		st_raddr = base + SA_W'(pos);
		tt_we    = 1'b0;
		tt_waddr = TI_W'(op_id_q);
		tt_wdata = {op_lv_q, now_q};
		tt_raddr = TI_W'(op_id_q);
		pk_we    = 1'b0;
		pk_waddr = cnt_q[TI_W-1:0];
		pk_raddr = p_q[TI_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_DEC;
			end
			S_DEC: begin
				unique case (mode_q)
					MODE_ENQ: state_d = S_PUT;
					MODE_SEL: state_d = sel_any ? S_SEL_RD : S_DONE;
					MODE_REM: state_d = S_RM_LV;
					MODE_AGE: state_d = S_BS_LV;
					default:  state_d = S_DONE;
				endcase
			end
			S_SEL_RD: begin
				st_raddr = base + SA_W'(cur_head);
				state_d  = S_SEL_DAT;
			end
			S_SEL_DAT: state_d = S_DONE;
			S_RM_LV: begin
				if (rm_skip) begin
					state_d = boost_q ? S_PUT : S_DONE;
				end else begin
					state_d = S_RM_CHK;
				end
			end
			S_RM_CHK: state_d = S_RM_RD;
			S_RM_RD: begin
				state_d = (k_q == cur_fill) ? S_RM_END : S_RM_CMP;
			end
			S_RM_CMP: begin
				// after the match every entry moves one place toward the head
				st_we   = found_q;
				state_d = S_RM_RD;
			end
			S_RM_END: state_d = boost_q ? S_PUT : S_DONE;
			S_PUT: begin
				st_waddr = base + SA_W'(cur_tail);
				st_wdata = op_id_q;
				st_we    = put_ok;
				tt_we    = put_ok;
				state_d  = boost_q ? S_BS_PRD : S_DONE;
			end
			S_BS_LV: state_d = (bl_q == '0) ? S_DONE : S_BS_RD;
			S_BS_RD: state_d = (k_q == cur_fill) ? S_BS_PRD : S_BS_ID;
			S_BS_ID: begin
				tt_raddr = TI_W'(st_rdata);
				state_d  = (32'(st_rdata) < NUM_TASKS) ? S_BS_TM : S_BS_RD;
			end
			S_BS_TM: begin
				pk_we   = older;
				state_d = S_BS_RD;
			end
			S_BS_PRD: state_d = (p_q == cnt_q) ? S_BS_LV : S_BS_PID;
			S_BS_PID: state_d = S_RM_LV;
			S_DONE: begin
				if (!m_tvalid_q || m_tready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// datapath and pointer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q      <= THR_RESET;
			idle_q     <= '0;
			tv_q       <= '0;
			tv_rd_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
			found_q    <= 1'b0;
			boost_q    <= 1'b0;
			k_q        <= '0;
			cnt_q      <= '0;
			p_q        <= '0;
			bl_q       <= '0;
			op_lv_q    <= '0;
			moved_q    <= '0;
			mode_q     <= MODE_ENQ;
			id_q       <= '0;
			lvl_q      <= '0;
			now_q      <= '0;
			op_id_q    <= '0;
			pid_q      <= '0;
			rpos_q     <= '0;
			prev_q     <= '0;
			res_id_q   <= '0;
			res_lv_q   <= '0;
			res_idle_q <= 1'b0;
			res_ok_q   <= 1'b0;
			m_id_q     <= '0;
			m_lv_q     <= '0;
			m_idle_q   <= 1'b0;
			m_ok_q     <= 1'b0;
			m_cnt_q    <= '0;
			for (int l = 0; l < NUM_LEVELS; l++) begin
				head_q[l] <= '0;
				tail_q[l] <= '0;
				fill_q[l] <= '0;
			end
		end else begin
			tv_rd_q <= tv_q[tt_raddr];

			// configuration writes
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_AGE_THR: thr_q  <= cfg_data;
					REG_IDLE_ID: idle_q <= cfg_data[ID_W-1:0];
					default: ;
				endcase
			end

			// output register loads a finished result, drains when taken
			if (state_q == S_DONE && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						mode_q <= mode_t'(s_tuser);
						id_q   <= s_tdata[S_ID_LO +: ID_W];
						lvl_q  <= s_tdata[S_LVL_LO +: LVL_W];
						now_q  <= TW'(s_tdata[S_NOW_LO +: NOW_W]);
					end
				end
				S_DEC: begin
					res_id_q   <= (mode_q == MODE_SEL && !sel_any) ? idle_q : '0;
					res_lv_q   <= '0;
					res_idle_q <= (mode_q == MODE_SEL && !sel_any);
					res_ok_q   <= 1'b0;
					boost_q    <= 1'b0;
					op_id_q    <= id_q;
					moved_q    <= '0;
					case (mode_q)
						MODE_ENQ: op_lv_q <= clamp_lv;
						MODE_SEL: op_lv_q <= sel_lv;
						MODE_AGE: bl_q <= LV_W'(NUM_LEVELS - 1);
						default: ;
					endcase
				end
				S_SEL_DAT: begin
					res_id_q        <= st_rdata;
					res_lv_q        <= LVL_W'(op_lv_q);
					res_ok_q        <= 1'b1;
					head_q[op_lv_q] <= (32'(cur_head) == NUM_TASKS - 1) ? '0
					                                                    : cur_head + 1'b1;
					fill_q[op_lv_q] <= cur_fill - 1'b1;
				end
				S_RM_LV: begin
					if (rm_skip && boost_q) op_lv_q <= bl_q - 1'b1;
				end
				S_RM_CHK: begin
					op_lv_q <= tt_lv;
					k_q     <= '0;
					found_q <= 1'b0;
				end
				S_RM_RD: rpos_q <= pos;
				S_RM_CMP: begin
					prev_q <= rpos_q;
					if (!found_q && st_rdata == op_id_q) found_q <= 1'b1;
					k_q <= k_q + 1'b1;
				end
				S_RM_END: begin
					if (found_q) begin
						fill_q[op_lv_q] <= cur_fill - 1'b1;
						tail_q[op_lv_q] <= (cur_tail == '0) ? QI_W'(NUM_TASKS - 1)
						                                    : cur_tail - 1'b1;
					end
					if (boost_q) begin
						op_lv_q <= bl_q - 1'b1;
					end else begin
						res_ok_q <= found_q;
					end
				end
				S_PUT: begin
					if (put_ok) begin
						tail_q[op_lv_q] <= (32'(cur_tail) == NUM_TASKS - 1) ? '0
						                                                    : cur_tail + 1'b1;
						fill_q[op_lv_q] <= cur_fill + 1'b1;
						tv_q[TI_W'(op_id_q)] <= 1'b1;
					end
					if (boost_q) begin
						moved_q <= moved_q + CNT_W'(put_ok);
						p_q     <= p_q + 1'b1;
					end else begin
						res_ok_q <= put_ok;
					end
				end
				S_BS_LV: begin
					k_q   <= '0;
					cnt_q <= '0;
					p_q   <= '0;
				end
				S_BS_RD: ;
				S_BS_ID: begin
					pid_q <= st_rdata;
					if (!(32'(st_rdata) < NUM_TASKS)) k_q <= k_q + 1'b1;
				end
				S_BS_TM: begin
					if (older) cnt_q <= cnt_q + 1'b1;
					k_q <= k_q + 1'b1;
				end
				S_BS_PRD: begin
					if (p_q == cnt_q) bl_q <= bl_q - 1'b1;
				end
				S_BS_PID: begin
					op_id_q <= pk_rdata;
					boost_q <= 1'b1;
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_id_q     <= res_id_q;
						m_lv_q     <= res_lv_q;
						m_idle_q   <= res_idle_q;
						m_ok_q     <= res_ok_q;
						m_cnt_q    <= moved_q;
					end
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	ap_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cur_fill) <= NUM_TASKS)
		else $error("queue fill count above capacity");

	ap_accept_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_DEC))
		else $error("accepted request not decoded");

	ap_age_id: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BS_TM) |-> (32'(pid_q) < NUM_TASKS))
		else $error("age compare on out of range task id");

	ap_shift_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RM_CMP && found_q) |-> (k_q != '0))
		else $error("gap close before any match");
`endif

endmodule

### bench/tb.sv
// tb: self-checking bench for the multilevel feedback queue scheduler top level
// depends on mfqs_pkg and multilevel_feedback_queue_scheduler_top; checks each result
// against a queue-level model of levels, task levels, entry times, or a typed row's result
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mfqs_pkg::*;

	localparam int NTASK = DEF_NUM_TASKS;
	localparam int NLVL  = DEF_NUM_LEVELS;

	typedef struct packed {
		logic [ID_W-1:0]  cid;
		logic [LVL_W-1:0] clvl;
		logic             idle;
		logic             ok;
		logic [CNT_W-1:0] nboost;
	} sched_res_t;

	typedef struct {
		mode_t            m;
		logic [ID_W-1:0]  id;
		logic [LVL_W-1:0] lvl;
		logic [NOW_W-1:0] now;
		bit               typed;
		sched_res_t       res;
	} req_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata;
	logic [MODE_W-1:0]    s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_DATA_W-1:0]  m_tdata;
	logic                 m_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [THR_W-1:0]     cfg_data;

	multilevel_feedback_queue_scheduler_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// scheduler shadow state
	logic [ID_W-1:0]  level_q [NLVL][$];
	logic [LVL_W-1:0] task_lvl [NTASK];
	logic [NOW_W-1:0] task_stamp [NTASK];
	logic [THR_W-1:0] age_thr;
	logic [ID_W-1:0]  idle_id;

	sched_res_t pending_res[$];
	int         n_err, n_req, n_res, n_boosted, n_idle_sel;
	bit         no_gaps;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#20ms;
		$display("%0t timeout, %0d results still pending", $time, pending_res.size());
		$display("FAILURE");
		$finish;
	end

	function automatic bit sched_put(int l, logic [ID_W-1:0] id, logic [NOW_W-1:0] t);
		if (l > NLVL - 1)
			l = NLVL - 1;
		if (level_q[l].size() >= NTASK)
			return 1'b0;
		level_q[l].push_back(id);
		task_lvl[id] = LVL_W'(l);
		task_stamp[id] = t;
		return 1'b1;
	endfunction

	function automatic bit sched_drop(logic [ID_W-1:0] id);
		int l;
		if (id == idle_id)
			return 1'b0;
		l = task_lvl[id];
		if (l >= NLVL)
			return 1'b0;
		for (int i = 0; i < level_q[l].size(); i++) begin
			if (level_q[l][i] == id) begin
				level_q[l].delete(i);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// move long-waiting tasks up one level, lowest priority first
	function automatic int sched_boost(logic [NOW_W-1:0] t);
		logic [ID_W-1:0] picked[$];
		int moved;
		moved = 0;
		for (int l = NLVL - 1; l > 0; l--) begin
			picked.delete();
			for (int i = 0; i < level_q[l].size(); i++)
				if (NOW_W'(t - task_stamp[level_q[l][i]]) > age_thr)
					picked.push_back(level_q[l][i]);
			foreach (picked[i]) begin
				void'(sched_drop(picked[i]));
				if (sched_put(l - 1, picked[i], t))
					moved++;
			end
		end
		return moved;
	endfunction

	function automatic sched_res_t sched_step(mode_t m, logic [ID_W-1:0] id,
			logic [LVL_W-1:0] lvl, logic [NOW_W-1:0] t);
		sched_res_t r;
		r = '0;
		case (m)
			MODE_ENQ: r.ok = sched_put(lvl, id, t);
			MODE_SEL: begin
				for (int l = 0; l < NLVL; l++) begin
					if (level_q[l].size() > 0) begin
						r.cid = level_q[l].pop_front();
						r.clvl = LVL_W'(l);
						r.ok = 1'b1;
						break;
					end
				end
				if (!r.ok) begin
					r.cid = idle_id;
					r.idle = 1'b1;
				end
			end
			MODE_REM: r.ok = sched_drop(id);
			default: r.nboost = CNT_W'(sched_boost(t));
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// issue one request and record what it should produce
	task automatic send_req(req_row_t row);
		int gap;
		sched_res_t r;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= row.m;
		s_tdata  <= {7'd0, row.now, row.lvl, row.id};
		do @(posedge clk); while (!s_tready);
		r = sched_step(row.m, row.id, row.lvl, row.now);
		pending_res.push_back(row.typed ? row.res : r);
		n_req++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_res.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_AGE_THR)
			age_thr = val;
		else if (idx == REG_IDLE_ID)
			idle_id = val[ID_W-1:0];
		@(posedge clk);
	endtask

	// output stall pattern, runs of ready and not ready
	int stall_left;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (!no_gaps && $urandom_range(0, 99) < 25) begin
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
				: $urandom_range(0, 3);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		sched_res_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.cid    = m_tdata[5:0];
			got.clvl   = m_tdata[8:6];
			got.ok     = m_tdata[9];
			got.nboost = m_tdata[18:10];
			got.idle   = m_tuser;
			n_res++;
			if (pending_res.size() == 0) begin
				$display("%0t unexpected result id=%0d lvl=%0d idle=%0b ok=%0b boosted=%0d",
					$time, got.cid, got.clvl, got.idle, got.ok, got.nboost);
				n_err++;
			end else begin
				want = pending_res.pop_front();
				if (got.idle)
					n_idle_sel++;
				n_boosted += got.nboost;
				if (got.cid !== want.cid)
					$display("%0t chosen_id exp %0d got %0d", $time, want.cid, got.cid);
				if (got.clvl !== want.clvl)
					$display("%0t chosen_level exp %0d got %0d", $time, want.clvl, got.clvl);
				if (got.idle !== want.idle)
					$display("%0t chose_idle exp %0b got %0b", $time, want.idle, got.idle);
				if (got.ok !== want.ok)
					$display("%0t op_ok exp %0b got %0b", $time, want.ok, got.ok);
				if (got.nboost !== want.nboost)
					$display("%0t boosted_count exp %0d got %0d", $time, want.nboost,
						got.nboost);
				if (got !== want)
					n_err++;
			end
		end
	end

	function automatic req_row_t mk(mode_t m, int id, int lvl, logic [NOW_W-1:0] t);
		req_row_t row;
		row.m = m;
		row.id = ID_W'(id);
		row.lvl = LVL_W'(lvl);
		row.now = t;
		row.typed = 1'b0;
		row.res = '0;
		return row;
	endfunction

	function automatic req_row_t mk_typed(mode_t m, int id, int lvl, logic [NOW_W-1:0] t,
			sched_res_t r);
		req_row_t row;
		row = mk(m, id, lvl, t);
		row.typed = 1'b1;
		row.res = r;
		return row;
	endfunction

	// random request, biased to a small pool of ids so removes hit
	function automatic req_row_t rand_req(ref logic [NOW_W-1:0] tick);
		int r;
		int id;
		r = $urandom_range(0, 99);
		id = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 15) : $urandom_range(0, 63);
		if ($urandom_range(0, 49) == 0)
			tick = $urandom();
		else
			tick = tick + $urandom_range(0, 60);
		if (r < 40)
			return mk(MODE_ENQ, id, $urandom_range(0, 7), tick);
		if (r < 65)
			return mk(MODE_SEL, $urandom_range(0, 63), $urandom_range(0, 7), tick);
		if (r < 90)
			return mk(MODE_REM, id, $urandom_range(0, 7), tick);
		return mk(MODE_AGE, $urandom_range(0, 63), $urandom_range(0, 7), tick);
	endfunction

	req_row_t   directed[$];
	logic [NOW_W-1:0] tick;
	logic [THR_W-1:0] thr_set[5];
	logic [ID_W-1:0]  idle_set[5];

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		stall_left = 0;
		no_gaps = 1'b0;
		n_err = 0;
		n_req = 0;
		n_res = 0;
		n_boosted = 0;
		n_idle_sel = 0;
		age_thr = THR_RESET;
		idle_id = '0;
		for (int i = 0; i < NTASK; i++) begin
			task_lvl[i] = '0;
			task_stamp[i] = '0;
		end
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed rows: empty scheduler, clamping, duplicates, boost and wrap
		directed.push_back(mk_typed(MODE_SEL, 0, 0, 0, '{cid: 0, clvl: 0, idle: 1, ok: 0,
			nboost: 0}));
		directed.push_back(mk_typed(MODE_REM, 0, 0, 0, '0));
		directed.push_back(mk_typed(MODE_AGE, 0, 0, 0, '0));
		directed.push_back(mk_typed(MODE_ENQ, 63, 7, 10, '{cid: 0, clvl: 0, idle: 0, ok: 1,
			nboost: 0}));
		directed.push_back(mk_typed(MODE_ENQ, 1, 0, 20, '{cid: 0, clvl: 0, idle: 0, ok: 1,
			nboost: 0}));
		directed.push_back(mk(MODE_ENQ, 1, 0, 21));
		directed.push_back(mk(MODE_ENQ, 5, 3, 30));
		directed.push_back(mk_typed(MODE_SEL, 0, 0, 40, '{cid: 1, clvl: 0, idle: 0, ok: 1,
			nboost: 0}));
		directed.push_back(mk(MODE_REM, 1, 0, 41));
		directed.push_back(mk(MODE_REM, 1, 0, 42));
		directed.push_back(mk(MODE_AGE, 0, 0, 100));
		directed.push_back(mk(MODE_AGE, 0, 0, 1000));
		directed.push_back(mk(MODE_ENQ, 42, 2, 32'hFFFF_FFF0));
		directed.push_back(mk(MODE_AGE, 0, 0, 32'h0000_0100));
		directed.push_back(mk(MODE_ENQ, 0, 4, 32'h0000_0100));
		directed.push_back(mk(MODE_REM, 63, 0, 32'h0000_0100));
		directed.push_back(mk(MODE_AGE, 0, 0, 32'h8000_0000));
		for (int i = 0; i < 6; i++)
			directed.push_back(mk(MODE_SEL, 0, 0, 32'h8000_0001));
		directed.push_back(mk(MODE_ENQ, 7, 5, 32'hFFFF_FFFF));
		directed.push_back(mk(MODE_SEL, 0, 0, 32'hFFFF_FFFF));
		foreach (directed[i])
			send_req(directed[i]);
		drain();

		// fill one level beyond its capacity, then empty everything
		for (int i = 0; i < 66; i++)
			send_req(mk(MODE_ENQ, $urandom_range(0, 63), 1, i));
		for (int i = 0; i < 70; i++)
			send_req(mk(MODE_SEL, 0, 0, 100));
		drain();

		// random phases over threshold and idle id settings, extremes included
		thr_set  = '{32'd0, 32'hFFFF_FFFF, 32'd200, 32'd40, 32'd0};
		idle_set = '{6'd63, 6'd0, 6'd5, 6'd0, 6'd0};
		thr_set[3] = $urandom_range(0, 400);
		idle_set[4] = ID_W'($urandom_range(0, 63));
		tick = 32'hFFFF_F000;
		for (int p = 0; p < 5; p++) begin
			write_reg(REG_AGE_THR, thr_set[p]);
			write_reg(REG_IDLE_ID, THR_W'(idle_set[p]));
			no_gaps = (p == 2);
			for (int i = 0; i < 100; i++)
				send_req(rand_req(tick));
			no_gaps = 1'b0;
			drain();
		end

		$display("%0d requests, %0d results, %0d tasks boosted, %0d idle selects",
			n_req, n_res, n_boosted, n_idle_sel);
		$display("five register settings incl. threshold 0 and max, one level overfilled");
		if (n_err == 0 && pending_res.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
